// ----- rtl/core/pphp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphp_pkg
// Shared types, phase codes, field size table and result record for the
// PES packet header parser.
// ----------------------------------------------------------------------------
package pphp_pkg;

    localparam int unsigned PH_W = 5;
    localparam int unsigned NPH  = 26;

    // Parse phase numbers
    localparam logic [PH_W-1:0] PH_HUNT    = 5'd0;
    localparam logic [PH_W-1:0] PH_ID      = 5'd1;
    localparam logic [PH_W-1:0] PH_LEN_HI  = 5'd2;
    localparam logic [PH_W-1:0] PH_LEN_LO  = 5'd3;
    localparam logic [PH_W-1:0] PH_FLAGS1  = 5'd4;
    localparam logic [PH_W-1:0] PH_FLAGS2  = 5'd5;
    localparam logic [PH_W-1:0] PH_HDRLEN  = 5'd6;
    localparam logic [PH_W-1:0] PH_PTS     = 5'd7;
    localparam logic [PH_W-1:0] PH_DTS     = 5'd8;
    localparam logic [PH_W-1:0] PH_ESCR    = 5'd9;
    localparam logic [PH_W-1:0] PH_ESRATE  = 5'd10;
    localparam logic [PH_W-1:0] PH_TRICK   = 5'd11;
    localparam logic [PH_W-1:0] PH_COPY    = 5'd12;
    localparam logic [PH_W-1:0] PH_CRC     = 5'd13;
    localparam logic [PH_W-1:0] PH_EXT     = 5'd14;
    localparam logic [PH_W-1:0] PH_PRIV    = 5'd15;
    localparam logic [PH_W-1:0] PH_PACKLEN = 5'd16;
    localparam logic [PH_W-1:0] PH_PACK    = 5'd17;
    localparam logic [PH_W-1:0] PH_SEQ     = 5'd18;
    localparam logic [PH_W-1:0] PH_PSTD    = 5'd19;
    localparam logic [PH_W-1:0] PH_EXT2LEN = 5'd20;
    localparam logic [PH_W-1:0] PH_EXT2    = 5'd21;
    localparam logic [PH_W-1:0] PH_STUFF   = 5'd22;
    localparam logic [PH_W-1:0] PH_PAYLOAD = 5'd23;
    localparam logic [PH_W-1:0] PH_PADDING = 5'd24;
    localparam logic [PH_W-1:0] PH_AFTER   = 5'd25;

    // One-hot parse state
    typedef enum logic [NPH-1:0] {
        ST_HUNT    = 26'h0000001,
        ST_ID      = 26'h0000002,
        ST_LEN_HI  = 26'h0000004,
        ST_LEN_LO  = 26'h0000008,
        ST_FLAGS1  = 26'h0000010,
        ST_FLAGS2  = 26'h0000020,
        ST_HDRLEN  = 26'h0000040,
        ST_PTS     = 26'h0000080,
        ST_DTS     = 26'h0000100,
        ST_ESCR    = 26'h0000200,
        ST_ESRATE  = 26'h0000400,
        ST_TRICK   = 26'h0000800,
        ST_COPY    = 26'h0001000,
        ST_CRC     = 26'h0002000,
        ST_EXT     = 26'h0004000,
        ST_PRIV    = 26'h0008000,
        ST_PACKLEN = 26'h0010000,
        ST_PACK    = 26'h0020000,
        ST_SEQ     = 26'h0040000,
        ST_PSTD    = 26'h0080000,
        ST_EXT2LEN = 26'h0100000,
        ST_EXT2    = 26'h0200000,
        ST_STUFF   = 26'h0400000,
        ST_PAYLOAD = 26'h0800000,
        ST_PADDING = 26'h1000000,
        ST_AFTER   = 26'h2000000
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_SYNTAX  = 3'd0;
    localparam logic [2:0] ERR_PTS     = 3'd1;
    localparam logic [2:0] ERR_DTS     = 3'd2;
    localparam logic [2:0] ERR_HDR_LEN = 3'd3;
    localparam logic [2:0] ERR_PKT_LEN = 3'd4;

    localparam logic [7:0] SID_MIN     = 8'hBC;
    localparam logic [7:0] SID_PADDING = 8'hBE;

    localparam int unsigned TS_W = 33;

    // Record handed from the classifier to the output stage
    typedef struct packed {
        logic [1:0]      kind;
        logic            transport;
        logic [12:0]     pid;
        logic [7:0]      stream;
        logic [7:0]      data;
        logic            first;
        logic [1:0]      pts_dts;
        logic [TS_W-1:0] pts;
        logic [TS_W-1:0] dts;
        logic [2:0]      code;
    } res_t;

    function automatic logic [PH_W-1:0] ph_index(input phase_t st);
        logic [PH_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NPH; i++) begin
            if (st[i])
            begin
                idx = idx | PH_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic phase_t ph_state(input logic [PH_W-1:0] idx);
        return phase_t'(NPH'(1) << idx);
    endfunction

    function automatic logic [7:0] fixed_size(input logic [PH_W-1:0] p);
        logic [7:0] s;
        unique case (p)
            PH_PTS, PH_DTS: s = 8'd5;
            PH_ESCR:        s = 8'd6;
            PH_ESRATE:      s = 8'd3;
            PH_TRICK, PH_COPY, PH_EXT, PH_PACKLEN, PH_EXT2LEN: s = 8'd1;
            PH_CRC, PH_SEQ, PH_PSTD: s = 8'd2;
            PH_PRIV:        s = 8'd16;
            default:        s = 8'd0;
        endcase
        return s;
    endfunction

    function automatic logic field_needed(input logic [PH_W-1:0] p, input logic [15:0] f);
        logic n;
        unique case (p)
            PH_PTS:     n = f[7];
            PH_DTS:     n = f[7] & f[6];
            PH_ESCR:    n = f[5];
            PH_ESRATE:  n = f[4];
            PH_TRICK:   n = f[3];
            PH_COPY:    n = f[2];
            PH_CRC:     n = f[1];
            PH_EXT:     n = f[0];
            PH_PRIV:    n = f[15];
            PH_PACKLEN: n = f[14];
            PH_SEQ:     n = f[13];
            PH_PSTD:    n = f[12];
            PH_EXT2LEN: n = f[8];
            default:    n = 1'b0;
        endcase
        return n;
    endfunction

    function automatic logic has_header(input logic [7:0] id);
        return !(id == 8'hBC || id == 8'hBE || id == 8'hBF || id == 8'hF0 ||
                 id == 8'hF1 || id == 8'hF2 || id == 8'hF8 || id == 8'hFF);
    endfunction

endpackage

// ----- rtl/core/pes_packet_header_parser_core.sv -----
`timescale 1ns / 1ps
// An accepted byte's result enters the result queue at the edge that takes it,
// and leaves it for the output register once that register is empty or drained.
// Throughput: one byte per cycle; the parser finishes each byte in the cycle
// it is taken, so the rate is bounded only by room in the result queue.
// The input stalls only while the QUEUE_DEPTH-entry result queue is full.
// Reset (rst_n low, asynchronous) returns the parser to the prefix hunt,
// empties the queue and the output register and clears both config registers.
// ----------------------------------------------------------------------------
// pes_packet_header_parser_core
// Byte-serial PES packet parser: prefix hunt, header checks, PTS/DTS
// extraction and payload tagging, with a queue decoupling parse and output.
// ----------------------------------------------------------------------------
module pes_packet_header_parser_core
    import pphp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    // input beats
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        unit_start,
    // result beats
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [12:0] route_id,
    output logic [7:0]  stream_code,
    output logic [7:0]  payload_byte,
    output logic        first_of_packet,
    output logic        pts_present,
    output logic        dts_present,
    output logic [32:0] pts_value,
    output logic [32:0] dts_value,
    output logic [2:0]  error_code
);

    localparam logic CFG_TRANSPORT = 1'b0;
    localparam logic CFG_PID       = 1'b1;

    logic        tmode_reg;
    logic [12:0] pid_reg;
    logic        step;
    logic        res_valid;
    res_t        res;
    res_t        head;
    logic        q_empty, q_full, q_pop;

    // Hold off input whenever the queue may not take this beat's result
    assign in_stall = q_full;
    assign step     = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmode_reg <= 1'b0;
            pid_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRANSPORT: tmode_reg <= cfg_data[0];
                CFG_PID:       pid_reg   <= cfg_data;
                default:       tmode_reg <= tmode_reg;
            endcase
        end
    end

    // Front: parse and classify each accepted byte
    pphp_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .data_byte      (data_byte),
        .unit_start     (unit_start),
        .transport_mode (tmode_reg),
        .stream_pid     (pid_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Decouple: results wait here while the output side stalls
    pphp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (q_pop),
        .pop_data  (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back: format and present result beats
    pphp_emit u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .rec_avail       (!q_empty),
        .rec             (head),
        .rec_pop         (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .route_id        (route_id),
        .stream_code     (stream_code),
        .payload_byte    (payload_byte),
        .first_of_packet (first_of_packet),
        .pts_present     (pts_present),
        .dts_present     (dts_present),
        .pts_value       (pts_value),
        .dts_value       (dts_value),
        .error_code      (error_code)
    );

endmodule

// ----- rtl/core/pphp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphp_parser
// Front end: parses one byte per beat and classifies it into at most one
// result record.
// ----------------------------------------------------------------------------
module pphp_parser
    import pphp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        unit_start,
    input  logic        transport_mode,
    input  logic [12:0] stream_pid,
    output logic        res_valid,
    output res_t        res
);

    phase_t          phase_reg;
    phase_t          phase_next;
    logic [7:0]      fbc_reg, fbc_next;
    logic [7:0]      hbl_reg, hbl_next;
    logic [15:0]     pbl_reg, pbl_next;
    logic            unb_reg, unb_next;
    logic [7:0]      cs_reg, cs_next;
    logic [15:0]     hfb_reg, hfb_next;
    logic [TS_W-1:0] pts_reg, pts_next;
    logic [TS_W-1:0] dts_reg, dts_next;

    always_comb
    begin
        logic [PH_W-1:0] ph;
        logic [PH_W-1:0] cur;
        logic [PH_W-1:0] adv_from;
        logic [PH_W-1:0] found_p;
        logic            found;
        logic            do_adv;
        logic            do_hd;
        logic            none;
        logic [1:0]      kind;
        logic [2:0]      code;
        logic [7:0]      pbyte;
        logic            pfirst;
        logic [7:0]      size;
        logic [7:0]      idx;
        logic [7:0]      len;
        logic [3:0]      want;
        logic            stop;
        logic [7:0]      b;

        b        = data_byte;
        cur      = ph_index(phase_reg);
        ph       = cur;
        fbc_next = fbc_reg;
        hbl_next = hbl_reg;
        pbl_next = pbl_reg;
        unb_next = unb_reg;
        cs_next  = cs_reg;
        hfb_next = hfb_reg;
        pts_next = pts_reg;
        dts_next = dts_reg;
        none     = 1'b1;
        kind     = KIND_PAYLOAD;
        code     = ERR_SYNTAX;
        pbyte    = '0;
        pfirst   = 1'b0;
        do_adv   = 1'b0;
        do_hd    = 1'b0;
        adv_from = PH_PTS;
        found    = 1'b0;
        found_p  = PH_STUFF;
        size     = '0;
        idx      = '0;
        len      = '0;
        want     = '0;
        stop     = 1'b0;

        // unit start restarts the prefix hunt
        if (unit_start)
        begin
            if (!(ph == PH_HUNT || ph == PH_AFTER ||
                  ((ph == PH_PAYLOAD || ph == PH_PADDING) && unb_reg)))
            begin
                none = 1'b0; kind = KIND_ERROR; code = ERR_PKT_LEN;
            end
            ph = PH_HUNT;
            fbc_next = '0;
        end

        if (ph >= PH_FLAGS1 && ph <= PH_PADDING && !unb_next)
        begin
            pbl_next = pbl_next - 16'd1;
        end

        if (ph == PH_HUNT)
        begin
            if (transport_mode)
            begin
                if (fbc_next == 8'd0 && !unit_start)
                begin
                    // drop bytes before a unit start
                end
                else if (fbc_next < 8'd2)
                begin
                    if (b == 8'd0)
                    begin
                        fbc_next = fbc_next + 8'd1;
                    end
                    else
                    begin
                        if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_SYNTAX; end
                        ph = PH_HUNT; fbc_next = '0;
                    end
                end
                else if (b == 8'd1)
                begin
                    ph = PH_ID;
                end
                else
                begin
                    if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_SYNTAX; end
                    ph = PH_HUNT; fbc_next = '0;
                end
            end
            else if (b == 8'd0)
            begin
                fbc_next = (fbc_next < 8'd2) ? fbc_next + 8'd1 : 8'd2;
            end
            else if (b == 8'd1 && fbc_next >= 8'd2)
            begin
                ph = PH_ID;
            end
            else
            begin
                fbc_next = '0;
            end
        end
        else if (ph == PH_ID)
        begin
            if (b < SID_MIN)
            begin
                if (transport_mode)
                begin
                    if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_SYNTAX; end
                    ph = PH_HUNT; fbc_next = '0;
                end
                else
                begin
                    ph = PH_HUNT;
                    fbc_next = (b == 8'd0) ? 8'd1 : 8'd0;
                end
            end
            else
            begin
                cs_next  = b;
                hfb_next = '0;
                pts_next = '0;
                dts_next = '0;
                ph = PH_LEN_HI;
            end
        end
        else if (ph == PH_LEN_HI)
        begin
            pbl_next = {b, 8'd0};
            ph = PH_LEN_LO;
        end
        else if (ph == PH_LEN_LO)
        begin
            pbl_next = {pbl_next[15:8], b};
            unb_next = (pbl_next == 16'd0);
            if (has_header(cs_next)) ph = PH_FLAGS1;
            else do_hd = 1'b1;
        end
        else if (ph == PH_FLAGS1)
        begin
            if (b[7:6] != 2'd2)
            begin
                if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_SYNTAX; end
                ph = PH_HUNT; fbc_next = '0;
            end
            else
            begin
                ph = PH_FLAGS2;
            end
        end
        else if (ph == PH_FLAGS2)
        begin
            hfb_next = {8'd0, b};
            if (b[7:6] == 2'd1)
            begin
                if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_SYNTAX; end
                ph = PH_HUNT; fbc_next = '0;
            end
            else
            begin
                ph = PH_HDRLEN;
            end
        end
        else if (ph == PH_HDRLEN)
        begin
            hbl_next = b;
            do_adv = 1'b1;
            adv_from = PH_PTS;
        end
        else if (ph == PH_STUFF)
        begin
            if (b != 8'hFF)
            begin
                if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_SYNTAX; end
                ph = PH_HUNT; fbc_next = '0;
            end
            else
            begin
                hbl_next = hbl_next - 8'd1;
                if (hbl_next == 8'd0) do_hd = 1'b1;
            end
        end
        else if (ph == PH_PAYLOAD)
        begin
            none   = 1'b0;
            kind   = KIND_PAYLOAD;
            pbyte  = b;
            pfirst = (fbc_next == 8'd0);
            fbc_next = 8'd1;
            if (!unb_next && pbl_next == 16'd0)
            begin
                ph = transport_mode ? PH_AFTER : PH_HUNT;
                fbc_next = '0;
            end
        end
        else if (ph == PH_PADDING)
        begin
            if (b != 8'hFF)
            begin
                if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_SYNTAX; end
                ph = PH_HUNT; fbc_next = '0;
            end
            else if (!unb_next && pbl_next == 16'd0)
            begin
                ph = transport_mode ? PH_AFTER : PH_HUNT;
                fbc_next = '0;
            end
        end
        else if (ph == PH_AFTER)
        begin
            if (transport_mode)
            begin
                if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_SYNTAX; end
                ph = PH_HUNT; fbc_next = '0;
            end
            else
            begin
                ph = PH_HUNT;
                fbc_next = (b == 8'd0) ? 8'd1 : 8'd0;
            end
        end
        else if (ph > PH_HDRLEN && ph < PH_STUFF)
        begin
            // one byte of an optional header field
            size = fixed_size(ph);
            if (fbc_next <= size) idx = size - fbc_next;
            if (ph == PH_PTS)
            begin
                want = (hfb_next[7:6] == 2'd3) ? 4'd3 : 4'd2;
                if (idx == 8'd0 && b[7:4] != want)
                begin
                    if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_PTS; end
                    ph = PH_HUNT; fbc_next = '0;
                    stop = 1'b1;
                end
                else if (idx == 8'd0)
                    pts_next = {30'd0, b[3:1]};
                else if (idx == 8'd1 || idx == 8'd3)
                    pts_next = {pts_next[TS_W-9:0], b};
                else
                    pts_next = {pts_next[TS_W-8:0], b[7:1]};
            end
            else if (ph == PH_DTS)
            begin
                if (idx == 8'd0 && b[7:4] != 4'd1)
                begin
                    if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_DTS; end
                    ph = PH_HUNT; fbc_next = '0;
                    stop = 1'b1;
                end
                else if (idx == 8'd0)
                    dts_next = {30'd0, b[3:1]};
                else if (idx == 8'd1 || idx == 8'd3)
                    dts_next = {dts_next[TS_W-9:0], b};
                else
                    dts_next = {dts_next[TS_W-8:0], b[7:1]};
            end
            else if (ph == PH_EXT)
                hfb_next = {b, hfb_next[7:0]};
            else if (ph == PH_PACKLEN)
                len = b;
            else if (ph == PH_EXT2LEN)
                len = {1'b0, b[6:0]};

            if (!stop)
            begin
                hbl_next = hbl_next - 8'd1;
                fbc_next = fbc_next - 8'd1;
                if (fbc_next != 8'd0)
                begin
                    if (hbl_next == 8'd0)
                    begin
                        if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_HDR_LEN; end
                        ph = PH_HUNT; fbc_next = '0;
                    end
                end
                else if ((ph == PH_PACKLEN || ph == PH_EXT2LEN) && len != 8'd0)
                begin
                    if (hbl_next == 8'd0)
                    begin
                        if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_HDR_LEN; end
                        ph = PH_HUNT; fbc_next = '0;
                    end
                    else
                    begin
                        ph = (ph == PH_PACKLEN) ? PH_PACK : PH_EXT2;
                        fbc_next = len;
                    end
                end
                else
                begin
                    do_adv = 1'b1;
                    if (ph == PH_PACKLEN) adv_from = PH_SEQ;
                    else if (ph == PH_EXT2LEN) adv_from = PH_STUFF;
                    else adv_from = ph + 5'd1;
                end
            end
        end
        else
        begin
            ph = PH_HUNT;
            fbc_next = '0;
        end

        // pick the next optional field that the flags call for
        if (do_adv)
        begin
            for (int i = PH_STUFF - 1; i >= PH_PTS; i--)
            begin
                if (PH_W'(i) >= adv_from && field_needed(PH_W'(i), hfb_next))
                begin
                    found = 1'b1;
                    found_p = PH_W'(i);
                end
            end
            if (found)
            begin
                if (hbl_next == 8'd0)
                begin
                    if (none) begin none = 1'b0; kind = KIND_ERROR; code = ERR_HDR_LEN; end
                    ph = PH_HUNT; fbc_next = '0;
                end
                else
                begin
                    ph = found_p;
                    fbc_next = fixed_size(found_p);
                end
            end
            else if (hbl_next == 8'd0)
                do_hd = 1'b1;
            else
                ph = PH_STUFF;
        end

        if (do_hd)
        begin
            if (none) begin none = 1'b0; kind = KIND_HEADER; end
            ph = (cs_next == SID_PADDING) ? PH_PADDING : PH_PAYLOAD;
            fbc_next = '0;
            if (!unb_next && pbl_next == 16'd0)
                ph = transport_mode ? PH_AFTER : PH_HUNT;
        end

        if (none && !unb_next && ph >= PH_FLAGS1 && ph <= PH_STUFF && pbl_next == 16'd0)
        begin
            none = 1'b0; kind = KIND_ERROR; code = ERR_PKT_LEN;
            ph = PH_HUNT; fbc_next = '0;
        end

        phase_next    = ph_state(ph);
        res_valid     = step && !none;
        res.kind      = kind;
        res.transport = transport_mode;
        res.pid       = stream_pid;
        res.stream    = cs_next;
        res.data      = pbyte;
        res.first     = pfirst;
        res.pts_dts   = hfb_next[7:6];
        res.pts       = pts_next;
        res.dts       = dts_next;
        res.code      = code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ST_HUNT;
            fbc_reg   <= '0;
            hbl_reg   <= '0;
            pbl_reg   <= '0;
            unb_reg   <= 1'b0;
            cs_reg    <= '0;
            hfb_reg   <= '0;
            pts_reg   <= '0;
            dts_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            hbl_reg   <= hbl_next;
            pbl_reg   <= pbl_next;
            unb_reg   <= unb_next;
            cs_reg    <= cs_next;
            hfb_reg   <= hfb_next;
            pts_reg   <= pts_next;
            dts_reg   <= dts_next;
        end
    end

endmodule

// ----- rtl/core/pphp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphp_queue
// Short FIFO of result records between the parser and the output stage.
// ----------------------------------------------------------------------------
module pphp_queue
    import pphp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    input  logic pop,
    output res_t pop_data,
    output logic empty,
    output logic full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    res_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CW'(DEPTH));
    assign pop_data = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        rd_next  = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_next;
            if (pop)  rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/pphp_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphp_emit
// Back end: formats a queued record into the output fields and holds it in
// the output register until the beat is taken.
// ----------------------------------------------------------------------------
module pphp_emit
    import pphp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rec_avail,
    input  res_t            rec,
    output logic            rec_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      kind,
    output logic [12:0]     route_id,
    output logic [7:0]      stream_code,
    output logic [7:0]      payload_byte,
    output logic            first_of_packet,
    output logic            pts_present,
    output logic            dts_present,
    output logic [TS_W-1:0] pts_value,
    output logic [TS_W-1:0] dts_value,
    output logic [2:0]      error_code
);

    logic load;
    logic pp, dp;

    // Load a waiting record whenever the output register is empty or being drained
    assign load    = rec_avail && (!out_valid || !out_stall);
    assign rec_pop = load;
    assign pp      = (rec.kind == KIND_HEADER) && rec.pts_dts[1];
    assign dp      = (rec.kind == KIND_HEADER) && (rec.pts_dts == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (load)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind            <= rec.kind;
            route_id        <= rec.transport ? rec.pid : {5'd0, rec.stream};
            stream_code     <= rec.stream;
            payload_byte    <= (rec.kind == KIND_PAYLOAD) ? rec.data : 8'd0;
            first_of_packet <= (rec.kind == KIND_PAYLOAD) && rec.first;
            pts_present     <= pp;
            dts_present     <= dp;
            pts_value       <= pp ? rec.pts : '0;
            dts_value       <= dp ? rec.dts : '0;
            error_code      <= (rec.kind == KIND_ERROR) ? rec.code : ERR_SYNTAX;
        end
    end

endmodule

// ----- verif/pes_packet_header_parser_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pes_packet_header_parser_core_tb
// Self-checking bench for the PES header parser: a short table of directed
// bytes, then random well-formed packets with noise and corruption, checked
// beat by beat against a behavioral parser under random input and output
// pacing, across program and transport stream settings.
// ----------------------------------------------------------------------------
module pes_packet_header_parser_core_tb;
    import pphp_pkg::*;

    localparam logic CFG_TRANSPORT_MODE = 1'b0;
    localparam logic CFG_STREAM_PID     = 1'b1;
    localparam logic [1:0] KIND_NONE    = 2'd3;
    localparam int WATCHDOG_LIMIT       = 2000;
    localparam int HOLD_CYCLES          = 200;
    localparam int PHASE_BEATS          = 240;

    // Bytes per optional header field, indexed by parse phase.
    localparam logic [7:0] FLD_BYTES [0:21] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd5, 8'd5, 8'd6, 8'd3,
        8'd1, 8'd1, 8'd2, 8'd1, 8'd16, 8'd1, 8'd0, 8'd2, 8'd2, 8'd1, 8'd0
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] route;
        logic [7:0]  stream;
        logic [7:0]  pbyte;
        logic        first;
        logic        pp;
        logic        dp;
        logic [32:0] pts;
        logic [32:0] dts;
        logic [2:0]  code;
    } beat_rec_t;

    // Directed row: byte, unit start, and an optional pinned kind/code.
    typedef struct packed {
        logic [7:0] d;
        logic       us;
        logic       pin;
        logic [1:0] k;
        logic [2:0] c;
    } dir_row_t;

    localparam int NDIR = 23;
    localparam dir_row_t DIR_ROWS [NDIR] = '{
        '{8'h00, 1'b1, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'hC0, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h09, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h80, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h80, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h05, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h21, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'hFF, 1'b0, 1'b1, KIND_HEADER,  ERR_SYNTAX},
        '{8'h00, 1'b0, 1'b1, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h00, 1'b1, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'hE0, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h80, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SYNTAX},
        '{8'h40, 1'b0, 1'b1, KIND_ERROR,   ERR_SYNTAX}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        unit_start;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [12:0] route_id;
    logic [7:0]  stream_code;
    logic [7:0]  payload_byte;
    logic        first_of_packet;
    logic        pts_present;
    logic        dts_present;
    logic [32:0] pts_value;
    logic [32:0] dts_value;
    logic [2:0]  error_code;

    pes_packet_header_parser_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .unit_start      (unit_start),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .route_id        (route_id),
        .stream_code     (stream_code),
        .payload_byte    (payload_byte),
        .first_of_packet (first_of_packet),
        .pts_present     (pts_present),
        .dts_present     (dts_present),
        .pts_value       (pts_value),
        .dts_value       (dts_value),
        .error_code      (error_code)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Behavioral parser: its own copy of the registers and parse state.
    // ------------------------------------------------------------------
    logic        m_transport;
    logic [12:0] m_pid;
    logic [4:0]  m_phase;
    logic [7:0]  m_fcnt;
    logic [7:0]  m_hdr_left;
    logic [15:0] m_pkt_left;
    logic        m_unbounded;
    logic [7:0]  m_stream;
    logic [15:0] m_flags;
    logic [32:0] m_pts;
    logic [32:0] m_dts;
    logic [1:0]  p_kind;
    logic [2:0]  p_code;
    logic [7:0]  p_byte;
    logic        p_first;

    beat_rec_t   pending_beats[$];   // expected result beats, oldest first
    int          fails;
    int          beats_in;
    bit          hold_req;           // ask the receiver for a long hold-off
    bit          gaps_on;
    int          burst_left;

    function automatic bit carries_header(input logic [7:0] id);
        case (id)
            8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    function automatic bit field_due(input logic [4:0] p);
        case (p)
            PH_PTS:     return m_flags[7];
            PH_DTS:     return m_flags[7] & m_flags[6];
            PH_ESCR:    return m_flags[5];
            PH_ESRATE:  return m_flags[4];
            PH_TRICK:   return m_flags[3];
            PH_COPY:    return m_flags[2];
            PH_CRC:     return m_flags[1];
            PH_EXT:     return m_flags[0];
            PH_PRIV:    return m_flags[15];
            PH_PACKLEN: return m_flags[14];
            PH_SEQ:     return m_flags[13];
            PH_PSTD:    return m_flags[12];
            PH_EXT2LEN: return m_flags[8];
            default:    return 1'b0;
        endcase
    endfunction

    function automatic void flag_error(input logic [2:0] code);
        if (p_kind == KIND_NONE)
        begin
            p_kind = KIND_ERROR;
            p_code = code;
        end
        m_phase = PH_HUNT;
        m_fcnt = 8'd0;
    endfunction

    function automatic void close_packet();
        m_phase = m_transport ? PH_AFTER : PH_HUNT;
        m_fcnt = 8'd0;
    endfunction

    function automatic void finish_header();
        if (p_kind == KIND_NONE)
            p_kind = KIND_HEADER;
        m_phase = (m_stream == SID_PADDING) ? PH_PADDING : PH_PAYLOAD;
        m_fcnt = 8'd0;
        if (!m_unbounded && m_pkt_left == 16'd0)
            close_packet();
    endfunction

    function automatic void enter_field(input logic [4:0] p, input logic [7:0] n);
        if (m_hdr_left == 8'd0)
            flag_error(ERR_HDR_LEN);
        else
        begin
            m_phase = p;
            m_fcnt = n;
        end
    endfunction

    function automatic void next_field(input logic [4:0] from);
        logic [4:0] p;
        p = from;
        while (p < PH_STUFF && !field_due(p))
            p = p + 5'd1;
        if (p < PH_STUFF)
            enter_field(p, FLD_BYTES[p]);
        else if (m_hdr_left == 8'd0)
            finish_header();
        else
            m_phase = PH_STUFF;
    endfunction

    // Shift one time stamp byte in: 3 bits, 8, 7, 8, 7.
    function automatic logic [32:0] ts_shift(input logic [32:0] v, input logic [7:0] pos,
                                             input logic [7:0] b);
        case (pos)
            8'd0:       return {30'd0, b[3:1]};
            8'd1, 8'd3: return {v[24:0], b};
            default:    return {v[25:0], b[7:1]};
        endcase
    endfunction

    function automatic void field_beat(input logic [7:0] b);
        logic [4:0] p;
        logic [7:0] pos;
        logic [7:0] len;
        logic [3:0] want;
        p = m_phase;
        pos = 8'd0;
        len = 8'd0;
        if (p < PH_STUFF && m_fcnt <= FLD_BYTES[p])
            pos = FLD_BYTES[p] - m_fcnt;
        if (p == PH_PTS)
        begin
            want = (m_flags[7:6] == 2'b11) ? 4'h3 : 4'h2;
            if (pos == 8'd0 && b[7:4] != want)
            begin
                flag_error(ERR_PTS);
                return;
            end
            m_pts = ts_shift(m_pts, pos, b);
        end
        else if (p == PH_DTS)
        begin
            if (pos == 8'd0 && b[7:4] != 4'h1)
            begin
                flag_error(ERR_DTS);
                return;
            end
            m_dts = ts_shift(m_dts, pos, b);
        end
        else if (p == PH_EXT)
            m_flags = {b, m_flags[7:0]};
        else if (p == PH_PACKLEN)
            len = b;
        else if (p == PH_EXT2LEN)
            len = {1'b0, b[6:0]};
        m_hdr_left = m_hdr_left - 8'd1;
        m_fcnt = m_fcnt - 8'd1;
        if (m_fcnt != 8'd0)
        begin
            if (m_hdr_left == 8'd0)
                flag_error(ERR_HDR_LEN);
            return;
        end
        if (p == PH_PACKLEN)
        begin
            if (len != 8'd0) enter_field(PH_PACK, len);
            else next_field(PH_SEQ);
        end
        else if (p == PH_EXT2LEN)
        begin
            if (len != 8'd0) enter_field(PH_EXT2, len);
            else next_field(PH_STUFF);
        end
        else
            next_field(p + 5'd1);
    endfunction

    // Advance the parser by one byte; return 1 with the beat it yields.
    function automatic bit parse_byte(input logic [7:0] b, input logic us,
                                      output beat_rec_t r);
        bit quiet;
        p_kind = KIND_NONE;
        p_code = 3'd0;
        p_byte = 8'd0;
        p_first = 1'b0;
        r = '0;

        if (us)
        begin
            quiet = m_phase == PH_HUNT || m_phase == PH_AFTER ||
                ((m_phase == PH_PAYLOAD || m_phase == PH_PADDING) && m_unbounded);
            if (!quiet)
                flag_error(ERR_PKT_LEN);
            m_phase = PH_HUNT;
            m_fcnt = 8'd0;
        end

        if (m_phase >= PH_FLAGS1 && m_phase <= PH_PADDING && !m_unbounded)
            m_pkt_left = m_pkt_left - 16'd1;

        case (m_phase)
            PH_HUNT:
            begin
                if (m_transport)
                begin
                    if (!(m_fcnt == 8'd0 && !us))
                    begin
                        if (m_fcnt < 8'd2)
                        begin
                            if (b == 8'h00) m_fcnt = m_fcnt + 8'd1;
                            else flag_error(ERR_SYNTAX);
                        end
                        else if (b == 8'h01)
                            m_phase = PH_ID;
                        else
                            flag_error(ERR_SYNTAX);
                    end
                end
                else if (b == 8'h00)
                    m_fcnt = (m_fcnt < 8'd2) ? m_fcnt + 8'd1 : 8'd2;
                else if (b == 8'h01 && m_fcnt >= 8'd2)
                    m_phase = PH_ID;
                else
                    m_fcnt = 8'd0;
            end
            PH_ID:
            begin
                if (b < SID_MIN)
                begin
                    if (m_transport)
                        flag_error(ERR_SYNTAX);
                    else
                    begin
                        m_phase = PH_HUNT;
                        m_fcnt = (b == 8'h00) ? 8'd1 : 8'd0;
                    end
                end
                else
                begin
                    m_stream = b;
                    m_flags = 16'd0;
                    m_pts = '0;
                    m_dts = '0;
                    m_phase = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                m_pkt_left = {b, 8'h00};
                m_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                m_pkt_left[7:0] = b;
                m_unbounded = (m_pkt_left == 16'd0);
                if (carries_header(m_stream)) m_phase = PH_FLAGS1;
                else finish_header();
            end
            PH_FLAGS1:
            begin
                if (b[7:6] != 2'b10) flag_error(ERR_SYNTAX);
                else m_phase = PH_FLAGS2;
            end
            PH_FLAGS2:
            begin
                m_flags = {8'h00, b};
                if (b[7:6] == 2'b01) flag_error(ERR_SYNTAX);
                else m_phase = PH_HDRLEN;
            end
            PH_HDRLEN:
            begin
                m_hdr_left = b;
                next_field(PH_PTS);
            end
            PH_STUFF:
            begin
                if (b != 8'hFF)
                    flag_error(ERR_SYNTAX);
                else
                begin
                    m_hdr_left = m_hdr_left - 8'd1;
                    if (m_hdr_left == 8'd0)
                        finish_header();
                end
            end
            PH_PAYLOAD:
            begin
                p_kind = KIND_PAYLOAD;
                p_byte = b;
                p_first = (m_fcnt == 8'd0);
                m_fcnt = 8'd1;
                if (!m_unbounded && m_pkt_left == 16'd0)
                    close_packet();
            end
            PH_PADDING:
            begin
                if (b != 8'hFF) flag_error(ERR_SYNTAX);
                else if (!m_unbounded && m_pkt_left == 16'd0) close_packet();
            end
            PH_AFTER:
            begin
                if (m_transport)
                    flag_error(ERR_SYNTAX);
                else
                begin
                    m_phase = PH_HUNT;
                    m_fcnt = (b == 8'h00) ? 8'd1 : 8'd0;
                end
            end
            default:
            begin
                if (m_phase > PH_HDRLEN && m_phase < PH_STUFF)
                    field_beat(b);
                else
                begin
                    m_phase = PH_HUNT;
                    m_fcnt = 8'd0;
                end
            end
        endcase

        if (p_kind == KIND_NONE && !m_unbounded && m_phase >= PH_FLAGS1 &&
            m_phase <= PH_STUFF && m_pkt_left == 16'd0)
            flag_error(ERR_PKT_LEN);

        if (p_kind == KIND_NONE)
            return 1'b0;
        r.kind = p_kind;
        r.route = m_transport ? m_pid : {5'd0, m_stream};
        r.stream = m_stream;
        if (p_kind == KIND_PAYLOAD)
        begin
            r.pbyte = p_byte;
            r.first = p_first;
        end
        else if (p_kind == KIND_HEADER)
        begin
            r.pp = m_flags[7];
            r.dp = m_flags[7] & m_flags[6];
            r.pts = r.pp ? m_pts : '0;
            r.dts = r.dp ? m_dts : '0;
        end
        else
            r.code = p_code;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    logic [7:0] pkt_bytes[$];
    logic       pkt_us[$];

    // Offer one byte, hold it until taken, then update the parser model.
    task automatic send_byte(input logic [7:0] b, input logic us,
                             output bit got, output beat_rec_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 12) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid   <= 1'b1;
        data_byte  <= b;
        unit_start <= us;
        do @(posedge clk); while (in_stall);
        beats_in++;
        got = parse_byte(b, us, r);
        if (got)
            pending_beats.push_back(r);
    endtask

    // Drop valid and wait until every expected beat is out, then let the
    // pipeline drain bytes that produced nothing.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TRANSPORT_MODE)
            m_transport = val[0];
        else
            m_pid = val;
    endtask

    task automatic push_b(input logic [7:0] b);
        pkt_bytes.push_back(b);
        pkt_us.push_back(1'b0);
    endtask

    task automatic push_rand(input int n);
        repeat (n) push_b(8'($urandom));
    endtask

    // Build one packet, mostly well formed, with noise and corruption.
    task automatic build_packet();
        logic [7:0] id;
        logic [7:0] f1;
        logic [7:0] f2;
        logic [7:0] ext;
        logic [7:0] hdr[$];
        logic [1:0] pd;
        logic [15:0] plen;
        int n;
        int sel;
        int hlen;
        pkt_bytes.delete();
        pkt_us.delete();

        // stray bytes between packets
        if ($urandom_range(0, 9) == 0)
            push_rand($urandom_range(1, 4));

        pkt_bytes.push_back(8'h00);
        pkt_us.push_back(m_transport ? ($urandom_range(0, 19) != 0)
                                     : ($urandom_range(0, 3) == 0));
        push_b(8'h00);
        push_b(($urandom_range(0, 29) == 0) ? 8'($urandom) : 8'h01);

        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3, 4: id = 8'($urandom_range(8'hC0, 8'hEF));
            5:             id = 8'hBD;
            6:             id = 8'hBE;
            7:             id = 8'($urandom);
            default:       id = 8'($urandom_range(8'hBC, 8'hFF));
        endcase
        push_b(id);

        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 16);
        hdr.delete();
        if (carries_header(id))
        begin
            f1 = {2'b10, 6'($urandom)};
            if ($urandom_range(0, 24) == 0)
                f1 = 8'($urandom);
            sel = $urandom_range(0, 19);
            pd = (sel < 6) ? 2'd0 : (sel < 13) ? 2'd2 : (sel < 19) ? 2'd3 : 2'd1;
            f2 = {pd, 6'($urandom) & 6'($urandom) & 6'($urandom)};
            if (pd[1])
            begin
                hdr.push_back({(pd == 2'd3) ? 4'h3 : 4'h2, 3'($urandom), 1'b1});
                if ($urandom_range(0, 29) == 0)
                    hdr[0] = 8'($urandom);
                repeat (4) hdr.push_back(8'($urandom));
            end
            if (pd == 2'd3)
            begin
                hdr.push_back({($urandom_range(0, 29) == 0) ? 4'($urandom) : 4'h1,
                               3'($urandom), 1'b1});
                repeat (4) hdr.push_back(8'($urandom));
            end
            if (f2[5]) repeat (6) hdr.push_back(8'($urandom));
            if (f2[4]) repeat (3) hdr.push_back(8'($urandom));
            if (f2[3]) hdr.push_back(8'($urandom));
            if (f2[2]) hdr.push_back(8'($urandom));
            if (f2[1]) repeat (2) hdr.push_back(8'($urandom));
            if (f2[0])
            begin
                ext = 8'($urandom) & 8'($urandom);
                hdr.push_back(ext);
                if (ext[7]) repeat (16) hdr.push_back(8'($urandom));
                if (ext[6])
                begin
                    sel = $urandom_range(0, 3);
                    hdr.push_back(8'(sel));
                    repeat (sel) hdr.push_back(8'($urandom));
                end
                if (ext[5]) repeat (2) hdr.push_back(8'($urandom));
                if (ext[4]) repeat (2) hdr.push_back(8'($urandom));
                if (ext[0])
                begin
                    sel = $urandom_range(0, 3);
                    hdr.push_back({1'($urandom), 7'(sel)});
                    repeat (sel) hdr.push_back(8'($urandom));
                end
            end
            repeat ($urandom_range(0, 3))
                hdr.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'hFF);
            hlen = hdr.size();
            if ($urandom_range(0, 19) == 0)
                hlen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                 : hlen + $urandom_range(0, 2) - 1;
            plen = 16'(3 + hdr.size() + n);
        end
        else
            plen = 16'(n);

        if ($urandom_range(0, 9) == 0)
            plen = 16'd0;
        else if ($urandom_range(0, 19) == 0)
            plen = plen + 16'($urandom_range(0, 4)) - 16'd2;
        else if ($urandom_range(0, 99) == 0)
            plen = 16'hFFFF;
        push_b(plen[15:8]);
        push_b(plen[7:0]);

        if (carries_header(id))
        begin
            push_b(f1);
            push_b(f2);
            push_b(8'(hlen));
            foreach (hdr[i]) push_b(hdr[i]);
        end
        repeat (n)
            push_b((id == SID_PADDING && $urandom_range(0, 29) != 0) ? 8'hFF : 8'($urandom));

        // occasional corruption anywhere in the packet
        if ($urandom_range(0, 14) == 0)
        begin
            sel = $urandom_range(0, pkt_bytes.size() - 1);
            pkt_bytes[sel] = 8'($urandom);
            if ($urandom_range(0, 3) == 0) pkt_us[sel] = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern, long hold-off, checking, watchdog
    // ------------------------------------------------------------------
    int stall_mode;
    int mode_cycles;
    int hold_left;
    int idle_cycles;

    task automatic check_field(input string nm, input logic [32:0] exp_v,
                               input logic [32:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", nm, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        beat_rec_t e;
        if (rst_n)
        begin
            // compare each delivered beat with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (pending_beats.size() == 0)
                begin
                    $error("result beat with nothing expected (kind %0d)", kind);
                    fails++;
                end
                else
                begin
                    e = pending_beats.pop_front();
                    check_field("kind", e.kind, kind);
                    check_field("route_id", e.route, route_id);
                    check_field("stream_code", e.stream, stream_code);
                    check_field("payload_byte", e.pbyte, payload_byte);
                    check_field("first_of_packet", e.first, first_of_packet);
                    check_field("pts_present", e.pp, pts_present);
                    check_field("dts_present", e.dp, dts_present);
                    check_field("pts_value", e.pts, pts_value);
                    check_field("dts_value", e.dts, dts_value);
                    check_field("error_code", e.code, error_code);
                end
            end

            // watchdog: cycles with no beat moving on either side
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("pes_packet_header_parser_core: mismatch");
                $finish;
            end
        end

        // pick the next stall value: long hold-off first, then the pattern
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (mode_cycles == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_cycles = $urandom_range(20, 120);
        end
        mode_cycles--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    logic        set_mode [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    logic [12:0] set_pid  [6] = '{13'd0, 13'h1FFF, 13'd1234, 13'd0, 13'd0, 13'h1FFF};

    initial
    begin
        bit got;
        beat_rec_t r;
        int quota;
        bit paused;
        fails = 0;
        beats_in = 0;
        hold_req = 1'b0;
        hold_left = 0;
        mode_cycles = 0;
        stall_mode = 0;
        idle_cycles = 0;
        burst_left = 0;
        gaps_on = 1'b0;

        // reset state of the model
        m_transport = 1'b0;
        m_pid = 13'd0;
        m_phase = PH_HUNT;
        m_fcnt = 8'd0;
        m_hdr_left = 8'd0;
        m_pkt_left = 16'd0;
        m_unbounded = 1'b0;
        m_stream = 8'd0;
        m_flags = 16'd0;
        m_pts = '0;
        m_dts = '0;

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_TRANSPORT_MODE;
        cfg_data   <= 13'd0;
        in_valid   <= 1'b0;
        data_byte  <= 8'd0;
        unit_start <= 1'b0;
        out_stall  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_TRANSPORT_MODE, 13'd0);
        write_reg(CFG_STREAM_PID, 13'd0);

        // directed bytes; pinned rows must also agree with the model
        for (int i = 0; i < NDIR; i++)
        begin
            send_byte(DIR_ROWS[i].d, DIR_ROWS[i].us, got, r);
            if (DIR_ROWS[i].pin && (!got || r.kind != DIR_ROWS[i].k ||
                (r.kind == KIND_ERROR && r.code != DIR_ROWS[i].c)))
            begin
                $error("directed row %0d: model gave kind %0d code %0d", i, r.kind, r.code);
                fails++;
            end
        end
        drain_results();

        // random phases across register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_TRANSPORT_MODE, {12'd0, set_mode[ph]});
            write_reg(CFG_STREAM_PID, (ph == 4) ? 13'($urandom) : set_pid[ph]);
            gaps_on = (ph != 3);
            quota = beats_in + PHASE_BEATS;
            paused = 1'b0;
            while (beats_in < quota)
            begin
                build_packet();
                foreach (pkt_bytes[i])
                    send_byte(pkt_bytes[i], pkt_us[i], got, r);
                // long receiver hold-off while bytes keep coming
                if (ph == 2 && !paused && beats_in > quota - PHASE_BEATS / 2)
                begin
                    hold_req = 1'b1;
                    paused = 1'b1;
                end
                // sender pause until every expected beat has come out
                if (ph == 1 && !paused && beats_in > quota - PHASE_BEATS / 2)
                begin
                    paused = 1'b1;
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending_beats.size() != 0)
                        @(posedge clk);
                end
            end
            drain_results();
        end

        if (fails == 0)
            $display("pes_packet_header_parser_core: match");
        else
            $display("pes_packet_header_parser_core: mismatch");
        $finish;
    end

endmodule
